// ===== src/brng_pkg.sv =====
package brng_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 36;
    localparam int THR_W    = 31;
    localparam int STEP_W   = 17;
    localparam int GAIN_W   = 17;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_OPEN_THR  = 2'd0;
    localparam logic [1:0] REG_CLOSE_THR = 2'd1;
    localparam logic [1:0] REG_ATTACK    = 2'd2;
    localparam logic [1:0] REG_RELEASE   = 2'd3;

    typedef struct packed {
        logic sample_en;  // stored sample enters the square/accumulate path
        logic mul_en;     // form threshold * count
        logic cmp_en;     // update gate flag, clear sum
    } pwr_ctrl_t;

    typedef struct packed {
        logic step_en;    // ramp gain one step
        logic load_en;    // load output register
        logic last;       // final result of the block
    } gain_ctrl_t;

endpackage

// ===== src/brng_store.sv =====
module brng_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [brng_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [brng_pkg::SAMPLE_W-1:0] rd_data
);

    logic [brng_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [brng_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/brng_power.sv =====
module brng_power #(
    parameter int CNT_W = 7
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  brng_pkg::pwr_ctrl_t                  ctrl,
    input  logic signed [brng_pkg::SAMPLE_W-1:0] sample,
    input  logic [CNT_W-1:0]                     fill_count,
    input  logic [brng_pkg::THR_W-1:0]           open_thr,
    input  logic [brng_pkg::THR_W-1:0]           close_thr,
    output logic                                 gate_open
);

    localparam int PROD_W = brng_pkg::THR_W + CNT_W;
    localparam int CMP_W  = (PROD_W > brng_pkg::SUM_W) ? PROD_W : brng_pkg::SUM_W;

    logic signed [brng_pkg::SQ_W-1:0]  sq;
    logic [brng_pkg::SQ_W-1:0]         sq_reg;
    logic                              sq_vld_reg, sq_vld_next;
    logic [brng_pkg::SUM_W:0]          sum_add;
    logic [brng_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [PROD_W-1:0]                 prod_reg;
    logic [brng_pkg::THR_W-1:0]        thr_sel;
    logic [CMP_W-1:0]                  sum_cmp, prod_cmp;
    logic                              gate_reg, gate_next;

    assign sq      = sample * sample;
    assign sum_add = {1'b0, sum_reg} + (brng_pkg::SUM_W+1)'(sq_reg);
    assign thr_sel = gate_reg ? close_thr : open_thr;
    assign sum_cmp  = CMP_W'(sum_reg);
    assign prod_cmp = CMP_W'(prod_reg);

    always_comb begin
        sq_vld_next = ctrl.sample_en;
        sum_next    = sum_reg;
        gate_next   = gate_reg;
        if (ctrl.cmp_en) begin
            sum_next = '0;
            if (!gate_reg) begin
                if (sum_cmp > prod_cmp) gate_next = 1'b1;
            end else begin
                if (sum_cmp < prod_cmp) gate_next = 1'b0;
            end
        end else if (sq_vld_reg) begin
            // saturating accumulate
            sum_next = sum_add[brng_pkg::SUM_W] ? brng_pkg::SUM_MAX
                                                : sum_add[brng_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            sum_reg    <= '0;
            gate_reg   <= 1'b0;
        end else begin
            sq_vld_reg <= sq_vld_next;
            sum_reg    <= sum_next;
            gate_reg   <= gate_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sample_en) begin
            sq_reg <= brng_pkg::SQ_W'(sq);
        end
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(thr_sel) * PROD_W'(fill_count);
        end
    end

    assign gate_open = gate_reg;

endmodule

// ===== src/brng_gain.sv =====
module brng_gain (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  brng_pkg::gain_ctrl_t                 ctrl,
    input  logic                                 gate_open,
    input  logic [brng_pkg::STEP_W-1:0]          attack_step,
    input  logic [brng_pkg::STEP_W-1:0]          release_step,
    input  logic signed [brng_pkg::SAMPLE_W-1:0] rd_data,
    output logic signed [brng_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 last_out
);

    logic [brng_pkg::GAIN_W-1:0]          gain_reg, gain_next;
    logic [brng_pkg::GAIN_W:0]            gain_up;
    logic signed [33:0]                   prod;
    logic signed [brng_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic                                 last_out_reg;

    assign gain_up = {1'b0, gain_reg} + (brng_pkg::GAIN_W+1)'(attack_step);

    always_comb begin
        gain_next = gain_reg;
        if (ctrl.step_en) begin
            if (gate_open && gain_reg < brng_pkg::GAIN_ONE) begin
                gain_next = (gain_up > (brng_pkg::GAIN_W+1)'(brng_pkg::GAIN_ONE))
                          ? brng_pkg::GAIN_ONE : gain_up[brng_pkg::GAIN_W-1:0];
            end else if (!gate_open && gain_reg != '0) begin
                gain_next = (gain_reg > release_step) ? gain_reg - release_step : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
        end else begin
            gain_reg <= gain_next;
        end
    end

    // floor(sample * gain / 2^16)
    assign prod = rd_data * $signed({1'b0, gain_reg});

    always_ff @(posedge aclk) begin
        if (ctrl.load_en) begin
            sample_out_reg <= prod[31:16];
            last_out_reg   <= ctrl.last;
        end
    end

    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

    gain_range_a: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= brng_pkg::GAIN_ONE)
        else $error("gain above unity");

endmodule

// ===== src/block_rms_noise_gate.sv =====
// Block noise gate with hysteresis on mean block power.
//
// Input channel (s_*): signed 16-bit samples, s_last_in_block marks the end
// of a block. Samples load one per cycle into the block store while the
// squares are summed. Samples beyond BLOCK_MAX in a block are dropped; a
// dropped sample marked last still closes the block.
// After the last sample, S_MUL forms threshold*count and S_CMP updates
// the gate flag; then each buffered sample is read (S_READ, store read
// port) and scaled by the ramped Q16 gain (S_MULT, output multiplier),
// one sample at a time, a stalled output holding the next read. Input is
// not taken during read-out.
// Output channel (m_*): one request per buffered sample, m_last_out on the
// final one. A stalled receiver holds the output register and the read-out
// pauses; the next block may start loading while the final result waits.
// Config: APB, 4 word registers (open/close threshold, attack/release step),
// for the user to write only while idle; the block does not enforce it. pready is tied high.
// Reset (aresetn, sync, low): gate closed, gain 0, counters and power sum
// cleared, registers at defaults. The store needs no clearing.
module block_rms_noise_gate #(
    parameter int BLOCK_MAX = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input samples
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    input  logic               s_last_in_block,
    // gated samples
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_out,
    output logic               m_last_out,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW    = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
    localparam int CNT_W = $clog2(BLOCK_MAX + 1);

    localparam logic [2:0] S_LOAD = 3'd0;  // taking samples
    localparam logic [2:0] S_MUL  = 3'd1;  // threshold * count, last add
    localparam logic [2:0] S_CMP  = 3'd2;  // gate decision
    localparam logic [2:0] S_READ = 3'd3;  // store read, gain step
    localparam logic [2:0] S_MULT = 3'd4;  // scale into output register

    logic [2:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            fill_count_reg, fill_count_next;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;
    logic                        m_valid_reg, m_valid_next;

    logic [brng_pkg::THR_W-1:0]  open_thr_reg, close_thr_reg;
    logic [brng_pkg::STEP_W-1:0] attack_reg, release_reg;

    logic                        in_acc, store_en, out_load, rd_last, cfg_wr;
    logic [brng_pkg::SAMPLE_W-1:0] rd_data;
    logic                        gate_open;
    brng_pkg::pwr_ctrl_t         pwr_ctrl;
    brng_pkg::gain_ctrl_t        gain_ctrl;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_thr_reg  <= 31'd1074;
            close_thr_reg <= 31'd107;
            attack_reg    <= 17'd137;
            release_reg   <= 17'd14;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                brng_pkg::REG_OPEN_THR:  open_thr_reg  <= pwdata[brng_pkg::THR_W-1:0];
                brng_pkg::REG_CLOSE_THR: close_thr_reg <= pwdata[brng_pkg::THR_W-1:0];
                brng_pkg::REG_ATTACK:    attack_reg    <= pwdata[brng_pkg::STEP_W-1:0];
                brng_pkg::REG_RELEASE:   release_reg   <= pwdata[brng_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            brng_pkg::REG_OPEN_THR:  prdata = 32'(open_thr_reg);
            brng_pkg::REG_CLOSE_THR: prdata = 32'(close_thr_reg);
            brng_pkg::REG_ATTACK:    prdata = 32'(attack_reg);
            brng_pkg::REG_RELEASE:   prdata = 32'(release_reg);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_ready  = (state_reg == S_LOAD);
    assign in_acc   = s_valid && s_ready;
    assign store_en = in_acc && (fill_count_reg < CNT_W'(BLOCK_MAX));
    assign out_load = (state_reg == S_MULT) && (!m_valid_reg || m_ready);
    assign rd_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == fill_count_reg);

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rd_idx_next     = rd_idx_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        if (out_load) m_valid_next = 1'b1;

        case (state_reg)
            S_LOAD: begin
                if (store_en) fill_count_next = fill_count_reg + CNT_W'(1);
                if (in_acc && s_last_in_block) state_next = S_MUL;
            end
            S_MUL: state_next = S_CMP;
            S_CMP: state_next = S_READ;
            S_READ: state_next = S_MULT;
            S_MULT: begin
                if (out_load) begin
                    if (rd_last) begin
                        state_next      = S_LOAD;
                        fill_count_next = '0;
                        rd_idx_next     = '0;
                    end else begin
                        state_next  = S_READ;
                        rd_idx_next = rd_idx_reg + AW'(1);
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            fill_count_reg <= '0;
            rd_idx_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_idx_reg     <= rd_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    assign pwr_ctrl.sample_en = store_en;
    assign pwr_ctrl.mul_en    = (state_reg == S_MUL);
    assign pwr_ctrl.cmp_en    = (state_reg == S_CMP);

    assign gain_ctrl.step_en = (state_reg == S_READ);
    assign gain_ctrl.load_en = out_load;
    assign gain_ctrl.last    = rd_last;

    // ---------------- datapath ----------------
    brng_store #(
        .DEPTH (BLOCK_MAX),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_en),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (s_sample_in),
        .rd_en   (state_reg == S_READ),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    brng_power #(
        .CNT_W (CNT_W)
    ) u_power (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (pwr_ctrl),
        .sample     (s_sample_in),
        .fill_count (fill_count_reg),
        .open_thr   (open_thr_reg),
        .close_thr  (close_thr_reg),
        .gate_open  (gate_open)
    );

    brng_gain u_gain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (gain_ctrl),
        .gate_open    (gate_open),
        .attack_step  (attack_reg),
        .release_step (release_reg),
        .rd_data      (rd_data),
        .sample_out   (m_sample_out),
        .last_out     (m_last_out)
    );

    // ---------------- checks ----------------
    fill_bound_a: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(BLOCK_MAX))
        else $error("fill count past block limit");

    rd_bound_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (CNT_W'(rd_idx_reg) < fill_count_reg))
        else $error("read index past stored samples");

    block_end_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && rd_last) |=> (state_reg == S_LOAD && fill_count_reg == '0))
        else $error("block not closed after final result");

    last_in_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_last_in_block) |=> (state_reg == S_MUL && !s_ready))
        else $error("last sample did not start the decision");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int BLK_MAX    = 64;
    localparam int HUSH_LIMIT = 3000;  // cycles without a request on either channel

    // one gated sample as it should leave the block
    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } gated_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_in     = '0;
    logic               s_last_in_block = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic signed [15:0] m_sample_out;
    logic               m_last_out;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [3:0]         paddr           = '0;
    logic [31:0]        pwdata          = '0;
    logic [31:0]        prdata;
    logic               pready;

    block_rms_noise_gate dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .s_last_in_block (s_last_in_block),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out),
        .m_last_out      (m_last_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 aclk = ~aclk;

    // Gate model state, mirrors the block after reset.
    logic [30:0]        open_thr    = 31'd1074;
    logic [30:0]        close_thr   = 31'd107;
    logic [16:0]        attack_q16  = 17'd137;
    logic [16:0]        release_q16 = 17'd14;
    logic signed [15:0] blk_buf [BLK_MAX];
    int                 blk_fill    = 0;
    longint             blk_power   = 0;
    bit                 gate_open   = 1'b0;
    int                 gain_now    = 0;

    gated_t gated_due[$];        // predicted outputs, oldest first
    gated_t next_gated;
    int     mismatches  = 0;
    int     items_sent  = 0;
    int     hush_cycles = 0;
    int     rx_hold_left = 0;    // receiver hold-off, counted down by the receiver
    bit     tx_idle_on  = 1'b1;
    bit     rx_idle_on  = 1'b1;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Buffers one accepted sample; on the block's last sample decides the gate
    // and queues every gated output of the block.
    task automatic predict_gated(input logic signed [15:0] smp, input logic last);
        int     n;
        int     k;
        int     target;
        longint prod;
        gated_t res;
        // samples past BLK_MAX are dropped, but a dropped last still ends the block
        if (blk_fill < BLK_MAX) begin
            blk_buf[blk_fill] = smp;
            blk_fill++;
            blk_power += longint'(smp) * longint'(smp);
            if (blk_power > longint'(brng_pkg::SUM_MAX))
                blk_power = longint'(brng_pkg::SUM_MAX);
        end
        if (last) begin
            n = blk_fill;
            // mean vs threshold without a divide; strict on both sides
            if (!gate_open) begin
                if (blk_power > longint'(open_thr) * n)
                    gate_open = 1'b1;
            end else if (blk_power < longint'(close_thr) * n) begin
                gate_open = 1'b0;
            end
            target = gate_open ? int'(brng_pkg::GAIN_ONE) : 0;
            for (k = 0; k < n; k++) begin
                // step first, then clamp to 0..1.0
                if (target > gain_now) begin
                    gain_now += int'(attack_q16);
                    if (gain_now > int'(brng_pkg::GAIN_ONE))
                        gain_now = int'(brng_pkg::GAIN_ONE);
                end else if (target < gain_now) begin
                    if (gain_now > int'(release_q16))
                        gain_now -= int'(release_q16);
                    else
                        gain_now = 0;
                end
                prod = longint'(blk_buf[k]) * gain_now;
                res.sample = prod[31:16];   // floor of the Q16 product
                res.last   = (k == n - 1);
                gated_due.push_back(res);
            end
            blk_fill  = 0;
            blk_power = 0;
        end
    endtask

    // Offers one sample and holds it until the request is taken.
    task automatic send_sample(input logic signed [15:0] smp, input logic last);
        @(negedge aclk);
        if (tx_idle_on) begin
            while ($urandom_range(99) < 9) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid         <= 1'b1;
        s_sample_in     <= smp;
        s_last_in_block <= last;
        do @(posedge aclk); while (!s_ready);
        predict_gated(smp, last);
        items_sent++;
    endtask

    function automatic logic signed [15:0] rand_sample(input int shift);
        logic signed [15:0] raw;
        raw = 16'($urandom);
        return raw >>> shift;
    endfunction

    task automatic send_block(input int len, input int shift);
        int i;
        for (i = 0; i < len; i++)
            send_sample(rand_sample(shift), i == len - 1);
    endtask

    // Drop valid, wait for every predicted output, then let the block go idle.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (gated_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);   // access edge, pready is tied high
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            brng_pkg::REG_OPEN_THR:  open_thr    = value[30:0];
            brng_pkg::REG_CLOSE_THR: close_thr   = value[30:0];
            brng_pkg::REG_ATTACK:    attack_q16  = value[16:0];
            brng_pkg::REG_RELEASE:   release_q16 = value[16:0];
            default: ;
        endcase
    endtask

    task automatic set_gate_config(input logic [31:0] open_v, input logic [31:0] close_v,
                                   input logic [31:0] att_v, input logic [31:0] rel_v);
        settle();
        write_reg(brng_pkg::REG_OPEN_THR, open_v);
        write_reg(brng_pkg::REG_CLOSE_THR, close_v);
        write_reg(brng_pkg::REG_ATTACK, att_v);
        write_reg(brng_pkg::REG_RELEASE, rel_v);
    endtask

    function automatic logic [31:0] rand_threshold();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 1 << $urandom_range(0, 30));
        endcase
    endfunction

    function automatic logic [31:0] rand_step();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'h1_FFFF;
            default: return $urandom_range(0, 1 << $urandom_range(0, 16));
        endcase
    endfunction

    // Reset defaults: full-scale opens, silence closes, ramp from zero gain.
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd32767, 1'b1);
        // silent block while open: mean 0 drops below close, gain ramps down
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd0, 1'b1);
        // tiny power stays below open
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);
    endtask

    // Threshold and step extremes: oversized steps clamp, zero steps hold,
    // a mean exactly at the open threshold does not open.
    task automatic test_register_extremes();
        set_gate_config(32'd0, 32'd0, 32'h1_FFFF, 32'h1_FFFF);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd7, 1'b1);
        set_gate_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        set_gate_config(32'h4000_0000, 32'h7FFF_FFFF, 32'h1_0000, 32'h1_0000);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        set_gate_config(32'h3FFF_FFFF, 32'd0, 32'h1_0000, 32'd0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd0, 1'b1);
    endtask

    // Full-scale 64-sample blocks saturate the sum; it opens against
    // 0x3FFFFFFF*64 and closes against 0x40000000*64. Then an overlong block
    // whose dropped tail carries the last mark.
    task automatic test_overlong_and_saturation();
        int i;
        set_gate_config(32'h3FFF_FFFF, 32'h4000_0000, 32'h800, 32'h800);
        for (i = 0; i < BLK_MAX; i++)
            send_sample(-16'sd32768, i == BLK_MAX - 1);
        for (i = 0; i < BLK_MAX; i++)
            send_sample(-16'sd32768, i == BLK_MAX - 1);
        set_gate_config(32'd1074, 32'd107, 32'd137, 32'd14);
        send_block(BLK_MAX + 2, 3);
    endtask

    // Receiver holds off long enough for the block to fill and back up.
    task automatic test_output_stall();
        settle();
        rx_hold_left = 400;
        send_block(12, 0);
        send_block(12, 2);
        send_block(12, 6);
    endtask

    // Sender waits for every output before offering the next block.
    task automatic test_drain_pause();
        int rep;
        for (rep = 0; rep < 3; rep++) begin
            send_block($urandom_range(1, 12), $urandom_range(0, 15));
            settle();
        end
    endtask

    // Mostly short blocks, some longer up to full, a few overlong; random amplitude so the
    // gate keeps toggling; registers reshuffled every few blocks.
    task automatic test_random_blocks();
        int blocks;
        int pick;
        int len;
        blocks = 0;
        while (items_sent < 330) begin
            if (blocks % 3 == 2)
                set_gate_config(rand_threshold(), rand_threshold(), rand_step(), rand_step());
            if (blocks == 2) begin
                tx_idle_on = 1'b0;   // stretch with no gaps on either side
                rx_idle_on = 1'b0;
            end
            if (blocks == 5) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(1, 16);
            else if (pick < 95)
                len = $urandom_range(17, BLK_MAX);
            else
                len = $urandom_range(BLK_MAX + 1, BLK_MAX + 8);
            send_block(len, $urandom_range(0, 15));
            blocks++;
        end
    endtask

    // Receiver: random stalls, or a counted hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_ready <= !(rx_idle_on && $urandom_range(99) < 9);
            end
        end
    end

    // Compare every taken output request with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (gated_due.size() == 0) begin
                report_mismatch("output with nothing expected", int'(m_sample_out), 0);
            end else begin
                next_gated = gated_due.pop_front();
                if (m_sample_out !== next_gated.sample)
                    report_mismatch("sample_out", int'(m_sample_out), int'(next_gated.sample));
                if (m_last_out !== next_gated.last)
                    report_mismatch("last_out", int'(m_last_out), int'(next_gated.last));
            end
        end
    end

    // Watchdog: too long with no request on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            hush_cycles = 0;
        else
            hush_cycles++;
        if (hush_cycles == HUSH_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_overlong_and_saturation();
        test_output_stall();
        test_drain_pause();
        test_random_blocks();
        settle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
